@@ rtl/sobel_nms_double_threshold_defines.svh @@
// Assertion macros used by sobel_nms_double_threshold.sv.
`ifndef SOBEL_NMS_DOUBLE_THRESHOLD_DEFINES_SVH
`define SOBEL_NMS_DOUBLE_THRESHOLD_DEFINES_SVH
`ifndef SYNTHESIS
`define SNDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SNDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SNDT_ASSERT_IMP(lbl, ante, cons)
`define SNDT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/sndt_pkg.sv @@
`default_nettype none
package sndt_pkg;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAG_LIMIT_DEF = 255;
  localparam int ROW_LIMIT     = 2048;
  localparam int SQRT_STEPS    = 11;
  localparam int CFG_AW        = 5;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BORDER       = 3'd2;
  localparam logic [2:0] REG_LOW          = 3'd3;
  localparam logic [2:0] REG_HIGH         = 3'd4;

  localparam logic [1:0] CLASS_NONE   = 2'd0;
  localparam logic [1:0] CLASS_WEAK   = 2'd1;
  localparam logic [1:0] CLASS_STRONG = 2'd2;

  localparam logic [1:0] DIR_0   = 2'd0;
  localparam logic [1:0] DIR_45  = 2'd1;
  localparam logic [1:0] DIR_90  = 2'd2;
  localparam logic [1:0] DIR_M45 = 2'd3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       start_of_frame;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  edge_magnitude;
    logic [1:0]  edge_class;
    logic [7:0]  edge_pixel;
    logic [10:0] out_column;
    logic [10:0] out_row;
  } out_req_t;
endpackage
`default_nettype wire

@@ rtl/sobel_nms_double_threshold.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    in_req_t (pixel, start_of_frame)
// out_      output     out_valid/out_stall  out_req_t (magnitude, class, position)
// cfg       APB write  psel/penable/pwrite  five registers at 4*i
// Each pixel passes through a read of both line memories, Sobel sums, squares,
// an 11-step bit-per-cycle square root, then suppression and write-back.
// The next request is taken only after the previous pixel is written back.
// Reset clears counters and windows and loads config defaults; line memories are not cleared.
// A waiting result holds the last stage until out_stall drops.
`default_nettype none
`include "sobel_nms_double_threshold_defines.svh"
module sobel_nms_double_threshold
  import sndt_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAG_LIMIT = MAG_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_req_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_req_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_MUL  = 6'b000100,
    S_SUM  = 6'b001000,
    S_SQRT = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [11:0] fw_r, fh_r;
  logic [3:0]  bm_r;
  logic [7:0]  lo_r, hi_r;

  logic [15:0] pmem [MAX_WIDTH];
  logic [19:0] gmem [MAX_WIDTH];
  logic [15:0] prd_r;
  logic [19:0] grd_r;

  logic [7:0]  pwin_r [9];
  logic [9:0]  gwin_r [9];
  logic [7:0]  pwin_nxt [9];
  logic [9:0]  gwin_nxt [9];

  logic [XW-1:0] col_r, x_r, x_in;
  logic [10:0]   row_r, y_r, y_in;
  logic [7:0]    pix_r;

  logic signed [10:0] gx_r, gy_r;
  logic [19:0] sqa_r;
  logic [21:0] t1_r, t2_r;
  logic [20:0] rem_r, root_r, bit_r;
  logic [3:0]  cnt_r;
  logic [1:0]  dir_r;
  logic        out_valid_r;
  out_req_t    out_data_r;

  logic [WW-1:0] w;
  logic [11:0]   h;
  logic [3:0]    m;
  logic          accept, cfg_wr, out_busy, emit;

  assign pready    = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_busy  = out_valid_r && out_stall;
  assign emit      = (x_r >= XW'(2)) && (y_r >= 11'd2);

  always_comb begin
    w = (fw_r < 12'd3) ? WW'(3) :
        (32'(fw_r) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_r);
    h = (fh_r < 12'd3) ? 12'd3 : (32'(fh_r) > 32'(ROW_LIMIT)) ? 12'(ROW_LIMIT) : fh_r;
    m = (bm_r == 4'd0) ? 4'd1 : bm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 12'd640;
      fh_r <= 12'd480;
      bm_r <= 4'd3;
      lo_r <= 8'd50;
      hi_r <= 8'd150;
    end else if (cfg_wr) begin
      unique case (paddr[CFG_AW-1:2])
        REG_FRAME_WIDTH:  fw_r <= pwdata[11:0];
        REG_FRAME_HEIGHT: fh_r <= pwdata[11:0];
        REG_BORDER:       bm_r <= pwdata[3:0];
        REG_LOW:          lo_r <= pwdata[7:0];
        REG_HIGH:         hi_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_AW-1:2])
      REG_FRAME_WIDTH:  prdata = {20'd0, fw_r};
      REG_FRAME_HEIGHT: prdata = {20'd0, fh_r};
      REG_BORDER:       prdata = {28'd0, bm_r};
      REG_LOW:          prdata = {24'd0, lo_r};
      REG_HIGH:         prdata = {24'd0, hi_r};
      default:          prdata = 32'd0;
    endcase
  end

  always_comb begin
    logic [11:0] yt;
    yt = 12'd0;
    if (in_data.start_of_frame) begin
      x_in = '0;
      y_in = 11'd0;
    end else begin
      x_in = col_r;
      yt   = {1'b0, row_r};
      if (WW'(col_r) >= w) begin
        x_in = '0;
        yt   = yt + 12'd1;
      end
      if (yt >= h) yt = 12'd0;
      y_in = yt[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prd_r <= pmem[x_in];
      grd_r <= gmem[x_in - XW'(1)];
    end
    if (state_r == S_RD) pmem[x_r] <= {prd_r[7:0], pix_r};
    if (state_r == S_FIN && !out_busy && x_r != '0) begin
      gmem[x_r - XW'(1)] <= {grd_r[9:0], gwin_nxt[8]};
    end
  end

  logic [10:0] colr, coll, rowb, rowt;
  logic [9:0]  ax, ay;
  logic [20:0] two_ax2, trial;
  logic [10:0] root_w;
  logic [7:0]  mag;
  logic        inside_border;
  logic [9:0]  gword;
  logic [7:0]  cen, na, nb;
  logic [1:0]  cls;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pwin_nxt[k*3]   = pwin_r[k*3+1];
      pwin_nxt[k*3+1] = pwin_r[k*3+2];
      gwin_nxt[k*3]   = gwin_r[k*3+1];
      gwin_nxt[k*3+1] = gwin_r[k*3+2];
    end
    pwin_nxt[2] = prd_r[15:8];
    pwin_nxt[5] = prd_r[7:0];
    pwin_nxt[8] = pix_r;

    colr = 11'(pwin_r[2]) + {2'b0, pwin_r[5], 1'b0} + 11'(pwin_r[8]);
    coll = 11'(pwin_r[0]) + {2'b0, pwin_r[3], 1'b0} + 11'(pwin_r[6]);
    rowb = 11'(pwin_r[6]) + {2'b0, pwin_r[7], 1'b0} + 11'(pwin_r[8]);
    rowt = 11'(pwin_r[0]) + {2'b0, pwin_r[1], 1'b0} + 11'(pwin_r[2]);

    ax = gx_r[10] ? 10'(-gx_r) : 10'(gx_r);
    ay = gy_r[10] ? 10'(-gy_r) : 10'(gy_r);
    two_ax2 = {sqa_r, 1'b0};
    trial = rem_r - (root_r + bit_r);

    root_w = root_r[10:0];
    mag = (32'(root_w) > MAG_LIMIT) ? 8'(MAG_LIMIT) : root_w[7:0];
    inside_border = (32'(x_r) >= 32'(m) + 1) && (32'(x_r) + 32'(m) <= 32'(w))
                 && (32'(y_r) >= 32'(m) + 1) && (32'(y_r) + 32'(m) <= 32'(h));
    gword = inside_border ? {dir_r, mag} : 10'd0;

    gwin_nxt[2] = grd_r[19:10];
    gwin_nxt[5] = grd_r[9:0];
    gwin_nxt[8] = gword;

    cen = gwin_nxt[4][7:0];
    unique case (gwin_nxt[4][9:8])
      DIR_0:   begin na = gwin_nxt[3][7:0]; nb = gwin_nxt[5][7:0]; end
      DIR_45:  begin na = gwin_nxt[0][7:0]; nb = gwin_nxt[8][7:0]; end
      DIR_90:  begin na = gwin_nxt[1][7:0]; nb = gwin_nxt[7][7:0]; end
      DIR_M45: begin na = gwin_nxt[2][7:0]; nb = gwin_nxt[6][7:0]; end
      default: begin na = 8'd0; nb = 8'd0; end
    endcase
    if (cen < na || cen < nb) cen = 8'd0;
    priority if (cen > hi_r) cls = CLASS_STRONG;
    else if (cen < lo_r)     cls = CLASS_NONE;
    else                     cls = CLASS_WEAK;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RD;
      S_RD:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SQRT;
      S_SQRT:  if (cnt_r == 4'(SQRT_STEPS - 1)) state_nxt = S_FIN;
      S_FIN:   if (!out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= 11'd0;
      out_valid_r <= 1'b0;
      cnt_r       <= 4'd0;
      for (int k = 0; k < 9; k++) begin
        pwin_r[k] <= 8'd0;
        gwin_r[k] <= 10'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && !out_busy && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r   <= x_in;
            y_r   <= y_in;
            pix_r <= in_data.pixel;
          end
        end
        S_RD: begin
          for (int k = 0; k < 9; k++) pwin_r[k] <= pwin_nxt[k];
          if (WW'(x_r) + WW'(1) >= w) begin
            col_r <= '0;
            row_r <= (12'({1'b0, y_r}) + 12'd1 >= h) ? 11'd0 : y_r + 11'd1;
          end else begin
            col_r <= x_r + XW'(1);
            row_r <= y_r;
          end
        end
        S_MUL: begin
          gx_r <= $signed(colr - coll);
          gy_r <= $signed(rowb - rowt);
        end
        S_SUM: begin
          sqa_r  <= 20'(ax) * 20'(ax);
          t1_r   <= 22'(11'(ax) + 11'(ay)) * 22'(11'(ax) + 11'(ay));
          t2_r   <= (ay > ax) ? 22'(ay - ax) * 22'(ay - ax) : 22'd0;
          rem_r  <= 21'(20'(ax) * 20'(ax)) + 21'(20'(ay) * 20'(ay));
          root_r <= 21'd0;
          bit_r  <= 21'd1 << 20;
          cnt_r  <= 4'd0;
        end
        S_SQRT: begin
          if (cnt_r == 4'd0) begin
            if (gx_r == 11'sd0)                          dir_r <= DIR_90;
            else if (t1_r <= 22'(two_ax2))               dir_r <= DIR_0;
            else if (ay > ax && t2_r > 22'(two_ax2))     dir_r <= DIR_90;
            else if ((gx_r > 0) == (gy_r > 0))           dir_r <= DIR_45;
            else                                         dir_r <= DIR_M45;
          end
          if (rem_r >= root_r + bit_r) begin
            rem_r  <= trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 4'd1;
        end
        S_FIN: begin
          if (!out_busy) begin
            if (x_r != '0) begin
              for (int k = 0; k < 9; k++) gwin_r[k] <= gwin_nxt[k];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && !out_busy && emit) begin
      out_data_r.edge_magnitude <= cen;
      out_data_r.edge_class     <= cls;
      out_data_r.edge_pixel     <= (cls == CLASS_STRONG) ? 8'd255 : 8'd0;
      out_data_r.out_column     <= 11'(32'(x_r) - 32'd2);
      out_data_r.out_row        <= y_r - 11'd2;
    end
  end

  `SNDT_ASSERT_NXT(a_one_at_a_time, accept, in_stall)
  `SNDT_ASSERT_IMP(a_sqrt_bound, state_r == S_SQRT, cnt_r < 4'(SQRT_STEPS))
  `SNDT_ASSERT_NXT(a_emit_shows, state_r == S_FIN && !out_busy && emit, out_valid_r)
endmodule
`default_nettype wire
